// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/sadtm_pkg.sv =====
// ----------------------------------------------------------------------------
// sadtm_pkg
// shared types and constants of the sad template digit matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sadtm_pkg;

	localparam int SUM_W  = 20;
	localparam int PIX_W  = 8;
	localparam int POS_W  = 12;
	localparam int TNUM_W = 3;

	localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
	localparam logic [SUM_W-1:0] LIMIT_RESET = 20'd417792;

	// request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_MATCH = 1'b1;

	// decoupling queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// one classified request as it travels from front to back
	typedef struct packed {
		logic              req;
		logic [TNUM_W-1:0] tsel;
		logic              first;
		logic              last;
		logic [POS_W-1:0]  pos;
		logic [PIX_W-1:0]  pix;
	} item_t;

endpackage

`default_nettype wire

// ===== hdl/sad_template_digit_matcher_top.sv =====
// ----------------------------------------------------------------------------
// sad_template_digit_matcher_top
// classifies a square image against stored digit templates by sum of
// absolute differences
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tdata: template, index, pixel
//                                               tuser: request kind
//  m_axis    out        m_axis_tvalid/tready    tdata: digit, sum
//                                               tuser: match flag
//  cfg       in         cfg_we                  cfg_wdata: match limit
//
//  one request per cycle is taken while the queue has room; each passes the
//  queue, the store read and one accumulate stage, then the result of a
//  last pixel climbs the minimum tree to the result register.
//  reset clears sums, queue and result; the template store is not cleared.
//  a held result stalls the back end, the queue keeps s_axis_tready up
//  for up to four more requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sad_template_digit_matcher_top #(
	parameter int IMAGE_SIDE     = 64,
	parameter int TEMPLATE_COUNT = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // template_number, pixel_index, pixel_value, pad
	input  wire logic        s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // best_digit, best_sum, pad
	output logic             m_axis_tuser,  // is_match
	input  wire logic        cfg_we,
	input  wire logic [19:0] cfg_wdata      // match_limit
);
	import sadtm_pkg::*;

	logic             push;
	item_t            push_item;
	logic             q_full;
	logic             pop;
	item_t            head;
	logic             head_valid;
	logic [SUM_W-1:0] match_limit_q;
	logic [2:0]       best_digit;
	logic [SUM_W-1:0] best_sum;

	// match limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			match_limit_q <= cfg_wdata;
		end
	end

	sadtm_front #(
		.IMAGE_SIDE     (IMAGE_SIDE),
		.TEMPLATE_COUNT (TEMPLATE_COUNT)
	) u_front (
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_req    (s_axis_tuser),
		.in_tnum   (s_axis_tdata[2:0]),
		.in_pos    (s_axis_tdata[14:3]),
		.in_pix    (s_axis_tdata[22:15]),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	sadtm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_item),
		.full      (q_full),
		.pop       (pop),
		.rdata     (head),
		.not_empty (head_valid)
	);

	sadtm_back #(
		.IMAGE_SIDE     (IMAGE_SIDE),
		.TEMPLATE_COUNT (TEMPLATE_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.match_limit (match_limit_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.best_digit  (best_digit),
		.best_sum    (best_sum),
		.is_match    (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, best_sum, best_digit};

endmodule

`default_nettype wire

// ===== hdl/sadtm_front.sv =====
// ----------------------------------------------------------------------------
// sadtm_front
// accepts stream requests, drops ignored ones and tags image start and end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sadtm_front #(
	parameter int IMAGE_SIDE     = 64,
	parameter int TEMPLATE_COUNT = 5
) (
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 in_req,
	input  wire logic [2:0]           in_tnum,
	input  wire logic [11:0]          in_pos,
	input  wire logic [7:0]           in_pix,
	output logic                      push,
	output sadtm_pkg::item_t          push_item,
	input  wire logic                 q_full
);
	import sadtm_pkg::*;

	localparam int PIXELS = IMAGE_SIDE * IMAGE_SIDE;

	logic [31:0] pos_ext;
	logic        pos_ok;
	logic        tnum_ok;
	logic        keep;

	// classify the request
	always_comb begin
		pos_ext = 32'(in_pos);
		pos_ok  = pos_ext < 32'(PIXELS);
		tnum_ok = (in_tnum != 3'd0) && (32'(in_tnum) <= 32'(TEMPLATE_COUNT));
		keep    = pos_ok && ((in_req == REQ_MATCH) || tnum_ok);
	end

	// a request is taken whenever the queue has room, ignored ones vanish here
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready && keep;

	always_comb begin
		push_item.req   = in_req;
		push_item.tsel  = in_tnum - 3'd1;
		push_item.first = (in_pos == '0);
		push_item.last  = (pos_ext == 32'(PIXELS - 1));
		push_item.pos   = in_pos;
		push_item.pix   = in_pix;
	end

endmodule

`default_nettype wire

// ===== hdl/sadtm_fifo.sv =====
// ----------------------------------------------------------------------------
// sadtm_fifo
// short queue that decouples request acceptance from execution
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sadtm_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sadtm_pkg::item_t wdata,
	output logic                  full,
	input  wire logic             pop,
	output sadtm_pkg::item_t      rdata,
	output logic                  not_empty
);
	import sadtm_pkg::*;

	item_t              slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full      = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = slot_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sadtm_back.sv =====
// ----------------------------------------------------------------------------
// sadtm_back
// template store, per-template sad lanes, registered minimum tree, result reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sadtm_back #(
	parameter int IMAGE_SIDE     = 64,
	parameter int TEMPLATE_COUNT = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire sadtm_pkg::item_t             head,
	input  wire logic                         head_valid,
	output logic                              pop,
	input  wire logic [sadtm_pkg::SUM_W-1:0]  match_limit,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [2:0]                        best_digit,
	output logic [sadtm_pkg::SUM_W-1:0]       best_sum,
	output logic                              is_match
);
	import sadtm_pkg::*;

	localparam int PIXELS = IMAGE_SIDE * IMAGE_SIDE;
	localparam int PIX_AW = $clog2(PIXELS);
	localparam int LEVELS = $clog2(TEMPLATE_COUNT);
	localparam int NPAD   = 1 << LEVELS;
	localparam int NODES  = 2 * NPAD - 1;
	localparam int IW     = LEVELS;

	logic              adv;
	logic [31:0]       pos_ext;
	logic [PIX_AW-1:0] addr;

	logic              vld_s1;
	logic              req_s1;
	logic              first_s1;
	logic              last_s1;
	logic [PIX_W-1:0]  pix_s1;

	logic [SUM_W-1:0]  lane_sum [TEMPLATE_COUNT];
	logic [SUM_W-1:0]  leaf_sum [NPAD];

	logic [SUM_W-1:0]  node_sum_q [NODES];
	logic [IW-1:0]     node_idx_q [NODES];
	logic [LEVELS:0]   lvl_vld_q;

	logic              out_valid_q;
	logic [2:0]        best_digit_q;
	logic [SUM_W-1:0]  best_sum_q;
	logic              is_match_q;

	// whole back end moves when the result register is free or being drained
	assign adv     = !out_valid_q || out_ready;
	assign pop     = adv && head_valid;
	assign pos_ext = 32'(head.pos);
	assign addr    = pos_ext[PIX_AW-1:0];

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1   <= head.req;
			first_s1 <= head.first;
			last_s1  <= head.last;
			pix_s1   <= head.pix;
		end
	end

	// one lane per template: store bank, registered read, running sum
	for (genvar t = 0; t < TEMPLATE_COUNT; t++) begin : g_lane
		logic [PIX_W-1:0] bank [PIXELS];
		logic [PIX_W-1:0] rd_s1;
		logic [SUM_W-1:0] sum_q;
		logic [PIX_W-1:0] diff;
		logic [SUM_W-1:0] base;
		logic [SUM_W:0]   acc;
		logic [SUM_W-1:0] nsum;

		// template store bank
		always_ff @(posedge clk) begin
			if (pop && (head.req == REQ_LOAD) && (32'(head.tsel) == 32'(t))) begin
				bank[addr] <= head.pix;
			end
			if (adv) begin
				rd_s1 <= bank[addr];
			end
		end

		// absolute difference and saturating accumulate
		always_comb begin
			diff = (pix_s1 > rd_s1) ? (pix_s1 - rd_s1) : (rd_s1 - pix_s1);
			base = first_s1 ? '0 : sum_q;
			acc  = {1'b0, base} + (SUM_W+1)'(diff);
			nsum = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_q <= '0;
			end else if (adv && vld_s1 && (req_s1 == REQ_MATCH)) begin
				sum_q <= last_s1 ? '0 : nsum;
			end
		end

		assign lane_sum[t] = nsum;
	end

	// pad the tree leaves, padding sits right of real lanes so ties keep them
	always_comb begin
		for (int i = 0; i < NPAD; i++) begin
			leaf_sum[i] = SUM_MAX;
		end
		for (int i = 0; i < TEMPLATE_COUNT; i++) begin
			leaf_sum[i] = lane_sum[i];
		end
	end

	// registered minimum tree, one level per stage, left child wins ties
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < NPAD - 1; n++) begin
				if (node_sum_q[2*n+2] < node_sum_q[2*n+1]) begin
					node_sum_q[n] <= node_sum_q[2*n+2];
					node_idx_q[n] <= node_idx_q[2*n+2];
				end else begin
					node_sum_q[n] <= node_sum_q[2*n+1];
					node_idx_q[n] <= node_idx_q[2*n+1];
				end
			end
			for (int i = 0; i < NPAD; i++) begin
				node_sum_q[NPAD-1+i] <= leaf_sum[i];
				node_idx_q[NPAD-1+i] <= IW'(i);
			end
		end
	end

	// tree valid chain and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			lvl_vld_q[LEVELS] <= vld_s1 && (req_s1 == REQ_MATCH) && last_s1;
			for (int l = 0; l < LEVELS; l++) begin
				lvl_vld_q[l] <= lvl_vld_q[l+1];
			end
			out_valid_q <= lvl_vld_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			best_digit_q <= 3'(32'(node_idx_q[0]) + 32'd1);
			best_sum_q   <= node_sum_q[0];
			is_match_q   <= (node_sum_q[0] <= match_limit);
		end
	end

	assign out_valid  = out_valid_q;
	assign best_digit = best_digit_q;
	assign best_sum   = best_sum_q;
	assign is_match   = is_match_q;

endmodule

`default_nettype wire

// ===== hdl/sadtm_checker.sv =====
// ----------------------------------------------------------------------------
// sadtm_checker
// port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sadtm_checker #(
	parameter int TEMPLATE_COUNT = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [19:0] cfg_wdata,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [23:0] m_axis_tdata,
	input  wire logic        m_axis_tuser
);
	import sadtm_pkg::*;

	logic [SUM_W-1:0] lim_q;

	// shadow of the match limit as seen on the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			lim_q <= cfg_wdata;
		end
	end

	// a stalled result stays put
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// winning digit names a real template
	`ASSERT_ALWAYS(a_digit_range, clk, arst_n, !m_axis_tvalid || ((m_axis_tdata[2:0] != 3'd0) && (32'(m_axis_tdata[2:0]) <= 32'(TEMPLATE_COUNT))))

	// match flag agrees with sum and current limit
	`ASSERT_ALWAYS(a_match_flag, clk, arst_n, !m_axis_tvalid || (m_axis_tuser == (m_axis_tdata[22:3] <= lim_q)))

endmodule

bind sad_template_digit_matcher_top sadtm_checker #(
	.TEMPLATE_COUNT (TEMPLATE_COUNT)
) u_sadtm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_wdata     (cfg_wdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/tb_sad_template_digit_matcher_top.sv =====
// ----------------------------------------------------------------------------
// tb_sad_template_digit_matcher_top
// self-checking bench: fills a working set of template positions, then
// streams short candidate images and pixel runs over it while a local sad
// model predicts each digit result, compared field by field on delivery
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_sad_template_digit_matcher_top;

	import sadtm_pkg::*;

	localparam int SIDE          = 64;
	localparam int TCOUNT        = 5;
	localparam int PIXELS        = SIDE * SIDE;
	localparam int LAST_POS      = PIXELS - 1;
	localparam int SPOTS         = 7;
	localparam int WORK_POS      = 16;
	localparam int WORK_SET      = WORK_POS + 1;
	localparam int SETTLE_CYCLES = 12;
	localparam int REPORT_MAX    = 10;
	localparam logic [SUM_W-1:0] LIMIT_TOP = 20'd1044480;

	typedef enum {IMG_NEAR, IMG_INVERT, IMG_NOISE} cand_kind_t;

	typedef struct {
		logic [TNUM_W-1:0] digit;
		logic [SUM_W-1:0]  sum;
		logic              hit;
	} digit_result_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;  // template_number, pixel_index, pixel_value, pad
	logic        s_axis_tuser  = 1'b0; // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // best_digit, best_sum, pad
	logic        m_axis_tuser;         // is_match
	logic        cfg_we        = 1'b0;
	logic [19:0] cfg_wdata     = '0;   // match_limit

	// local copy of the block state
	logic [PIX_W-1:0] tmpl_mem [TCOUNT][PIXELS];
	logic [SUM_W-1:0] sad_acc [TCOUNT];
	logic [SUM_W-1:0] limit_shadow = LIMIT_RESET;

	digit_result_t pending_digits [$];
	digit_result_t want;
	int            fail_count     = 0;
	int            send_gap_pct   = 0;
	int            recv_stall_pct = 0;

	sad_template_digit_matcher_top #(
		.IMAGE_SIDE    (SIDE),
		.TEMPLATE_COUNT(TCOUNT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#20_000_000;
		$display("sad_template_digit_matcher_top verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input int unsigned exp_v,
			input int unsigned got_v);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
	endtask

	// sad model: store writes, per-template accumulation, winner at last pixel
	task automatic accumulate_sad(input logic req, input logic [TNUM_W-1:0] tn,
			input logic [POS_W-1:0] pos, input logic [PIX_W-1:0] pix);
		logic [PIX_W-1:0] tp;
		logic [PIX_W-1:0] d;
		logic [SUM_W:0]   total;
		int               best;
		digit_result_t    r;
		if (pos >= PIXELS)
			return;
		if (req == REQ_LOAD) begin
			if (tn >= 1 && tn <= TCOUNT)
				tmpl_mem[tn - 1][pos] = pix;
			return;
		end
		for (int t = 0; t < TCOUNT; t++) begin
			tp = tmpl_mem[t][pos];
			d = (pix > tp) ? pix - tp : tp - pix;
			total = ((pos == 0) ? '0 : {1'b0, sad_acc[t]}) + d;
			sad_acc[t] = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
		end
		if (pos != LAST_POS)
			return;
		// lowest sum wins, earlier template on ties
		best = 0;
		for (int t = 1; t < TCOUNT; t++)
			if (sad_acc[t] < sad_acc[best])
				best = t;
		r.digit = TNUM_W'(best + 1);
		r.sum = sad_acc[best];
		r.hit = (sad_acc[best] <= limit_shadow);
		pending_digits = {pending_digits, r};
		for (int t = 0; t < TCOUNT; t++)
			sad_acc[t] = '0;
	endtask

	// one request on s_axis, with random idle cycles ahead of it
	task automatic send_request(input logic req, input logic [TNUM_W-1:0] tn,
			input logic [POS_W-1:0] pos, input logic [PIX_W-1:0] pix);
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {1'b0, pix, pos, tn};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		accumulate_sad(req, tn, pos, pix);
	endtask

	// stop sending, let every pending result arrive, then let the pipe settle
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [SUM_W-1:0] value);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_shadow = value;
	endtask

	// working set: the first WORK_POS raster positions and the last one
	function automatic int work_pos(input int k);
		return (k == WORK_POS) ? LAST_POS : k;
	endfunction

	function automatic logic [PIX_W-1:0] candidate_pixel(input cand_kind_t kind,
			input int tsel, input int p, input int noise_max);
		int v;
		case (kind)
			IMG_NEAR: begin
				v = int'(tmpl_mem[tsel - 1][p]) + int'($urandom_range(2 * noise_max))
					- noise_max;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
			end
			IMG_INVERT: v = 255 - int'(tmpl_mem[tsel - 1][p]);
			default: v = $urandom_range(255);
		endcase
		return PIX_W'(v);
	endfunction

	// a short image over the working set, in raster or shuffled order,
	// with optional load requests mixed in
	task automatic stream_image(input cand_kind_t kind, input int tsel, input int noise_max,
			input bit shuffled, input int load_pct);
		int order [WORK_SET];
		int j;
		int tmp;
		int p;
		for (int i = 0; i < WORK_SET; i++)
			order[i] = i;
		// last raster position stays at the end
		if (shuffled)
			for (int i = WORK_SET - 2; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		for (int i = 0; i < WORK_SET; i++) begin
			p = work_pos(order[i]);
			if (load_pct != 0 && $urandom_range(99) < load_pct) begin
				tmp = work_pos($urandom_range(WORK_POS));
				send_request(REQ_LOAD, TNUM_W'($urandom_range(1, TCOUNT)),
					tmp[POS_W-1:0], PIX_W'($urandom));
			end
			send_request(REQ_MATCH, TNUM_W'($urandom), p[POS_W-1:0],
				candidate_pixel(kind, tsel, p, noise_max));
		end
	endtask

	function automatic int spot_pos(input int k);
		return (k == SPOTS - 1) ? LAST_POS : k + 1;
	endfunction

	// set the spot positions (1..6 and the last one) of every template
	task automatic load_spots(input logic [PIX_W-1:0] v1, v2, v3, v4, v5);
		logic [PIX_W-1:0] vals [TCOUNT];
		int p;
		vals[0] = v1;
		vals[1] = v2;
		vals[2] = v3;
		vals[3] = v4;
		vals[4] = v5;
		for (int k = 0; k < SPOTS; k++) begin
			p = spot_pos(k);
			for (int t = 0; t < TCOUNT; t++)
				send_request(REQ_LOAD, TNUM_W'(t + 1), p[POS_W-1:0], vals[t]);
		end
	endtask

	// short image over the spot positions only, ends on the last position
	task automatic run_spots(input logic [PIX_W-1:0] v);
		int p;
		for (int k = 0; k < SPOTS; k++) begin
			p = spot_pos(k);
			send_request(REQ_MATCH, TNUM_W'($urandom), p[POS_W-1:0], v);
		end
	endtask

	// fill the working set of every template, extremes at the start of each
	task automatic test_template_load();
		logic [PIX_W-1:0] v;
		int p;
		for (int k = 0; k < WORK_SET; k++) begin
			p = work_pos(k);
			for (int t = 1; t <= TCOUNT; t++) begin
				v = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : PIX_W'($urandom);
				send_request(REQ_LOAD, TNUM_W'(t), p[POS_W-1:0], v);
			end
		end
	endtask

	// equal sums go to the lower template number
	task automatic test_tie_break();
		load_spots(8'd200, 8'd200, 8'd50, 8'd200, 8'd50);
		run_spots(8'd60);
		load_spots(8'd100, 8'd100, 8'd100, 8'd100, 8'd100);
		run_spots(8'd100);
	endtask

	// loads naming template 0 or any number above the count leave the store alone
	task automatic test_ignored_loads();
		int p;
		load_spots(8'd255, 8'd0, 8'd255, 8'd0, 8'd128);
		for (int k = 0; k < SPOTS; k++) begin
			p = spot_pos(k);
			send_request(REQ_LOAD, 3'd0, p[POS_W-1:0], 8'd7);
			for (int tn = TCOUNT + 1; tn < 8; tn++)
				send_request(REQ_LOAD, TNUM_W'(tn), p[POS_W-1:0], 8'd7);
		end
		run_spots(8'd255);
		run_spots(8'd0);
	endtask

	// match flag right at the limit and one above it
	task automatic test_limit_edge();
		load_spots(8'd200, 8'd200, 8'd50, 8'd200, 8'd50);
		set_limit(20'd70);
		run_spots(8'd60);
		set_limit(20'd69);
		run_spots(8'd60);
	endtask

	// short images: exact copy at limit zero, inverted copy, shuffled order
	task automatic test_short_images();
		set_limit('0);
		stream_image(IMG_NEAR, 2, 0, 1'b0, 0);
		stream_image(IMG_INVERT, 1, 0, 1'b0, 0);
		set_limit(LIMIT_RESET);
		stream_image(IMG_NOISE, 1, 0, 1'b1, 0);
	endtask

	// mixed short images and pixel runs with random content and stray loads
	task automatic test_random_traffic(input int units);
		cand_kind_t kind;
		int         len;
		int         r;
		int         p;
		set_limit(SUM_W'($urandom_range(LIMIT_TOP)));
		repeat (units) begin
			if ($urandom_range(9) < 3) begin
				r = $urandom_range(2);
				kind = (r == 0) ? IMG_NEAR : (r == 1) ? IMG_INVERT : IMG_NOISE;
				stream_image(kind, $urandom_range(1, TCOUNT), $urandom_range(40),
					($urandom_range(7) == 0), 3);
			end else begin
				len = $urandom_range(1, 40);
				repeat (len) begin
					r = $urandom_range(99);
					if (r < 75) begin
						p = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, WORK_POS - 1);
						send_request(REQ_MATCH, TNUM_W'($urandom), p[POS_W-1:0],
							PIX_W'($urandom));
					end else if (r < 95) begin
						p = work_pos($urandom_range(WORK_POS));
						send_request(REQ_LOAD, TNUM_W'($urandom_range(1, TCOUNT)),
							p[POS_W-1:0], PIX_W'($urandom));
					end else begin
						send_request(REQ_LOAD, ($urandom_range(1) == 0) ? 3'd0 : 3'd7,
							POS_W'($urandom_range(LAST_POS)), PIX_W'($urandom));
					end
				end
				send_request(REQ_MATCH, TNUM_W'($urandom), POS_W'(LAST_POS),
					PIX_W'($urandom));
			end
			// at random, hold the sender until the result is out
			if ($urandom_range(4) == 0)
				wait_for_results();
		end
	endtask

	// result checker and random stall on m_axis
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_digits.size() == 0) begin
					report_mismatch("result with nothing pending", 0, 32'(m_axis_tdata));
				end else begin
					want = pending_digits.pop_front();
					if (m_axis_tdata[2:0] !== want.digit)
						report_mismatch("best_digit", 32'(want.digit),
							32'(m_axis_tdata[2:0]));
					if (m_axis_tdata[22:3] !== want.sum)
						report_mismatch("best_sum", 32'(want.sum), 32'(m_axis_tdata[22:3]));
					if (m_axis_tuser !== want.hit)
						report_mismatch("is_match", 32'(want.hit), 32'(m_axis_tuser));
				end
			end
		end
	end

	// test sequence
	initial begin
		for (int t = 0; t < TCOUNT; t++)
			sad_acc[t] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 37;
		recv_stall_pct = 51;
		test_template_load();
		test_tie_break();
		test_ignored_loads();
		test_limit_edge();
		test_short_images();
		test_random_traffic(5);

		send_gap_pct = 51;
		recv_stall_pct = 37;
		test_random_traffic(5);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(5);

		wait_for_results();
		if (fail_count == 0)
			$display("sad_template_digit_matcher_top verification clean");
		else
			$display("sad_template_digit_matcher_top verification failed");
		$finish;
	end

endmodule

`default_nettype wire
